### sv/per_host_traffic_counter_table_defines.svh
// Assertion macros for the per-host traffic counter table.
// Used by per_host_traffic_counter_table; expects clk and rst in scope.
`ifndef PER_HOST_TRAFFIC_COUNTER_TABLE_DEFINES_SVH
`define PER_HOST_TRAFFIC_COUNTER_TABLE_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define PHTC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("phtc check failed");
// next-cycle implication
`define PHTC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("phtc check failed");
`else
`define PHTC_ASSERT_IMP(label, ante, cons)
`define PHTC_ASSERT_NXT(label, ante, cons)
`endif
`endif

### sv/phtc_pkg.sv
// Shared constants, types and state codes of the per-host traffic counter table.
// Used by phtc_search, phtc_counters and per_host_traffic_counter_table.
package phtc_pkg;

  // table size and derived widths
  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  // field widths
  localparam int ADDR_W     = 32;
  localparam int LEN_W      = 16;
  localparam int KIND_W     = 2;
  localparam int PKT_W      = 32;
  localparam int BYTE_W     = 48;
  localparam int KD_W       = 32;
  localparam int KD_LANES   = 8;
  localparam int LANE_W     = 3;
  localparam int OUT_IDX_W  = 6;

  // stream widths
  localparam int S_TDATA_W  = ((ADDR_W + LEN_W) + 7) / 8 * 8;
  localparam int S_TUSER_W  = 1 + KIND_W;
  localparam int M_TDATA_W  = ((OUT_IDX_W + PKT_W + BYTE_W + KD_W) + 7) / 8 * 8;
  localparam int M_TUSER_W  = 2;

  // counters of one host
  typedef struct packed {
    logic [PKT_W-1:0]  sent_pkts;
    logic [PKT_W-1:0]  rcvd_pkts;
    logic [BYTE_W-1:0] sent_bytes;
    logic [BYTE_W-1:0] rcvd_bytes;
    logic [BYTE_W-1:0] all_bytes;
  } entry_t;

  // eight kind-by-direction counters of one host
  typedef logic [KD_LANES-1:0][KD_W-1:0] kd_row_t;

  // outcome of a table search
  typedef struct packed {
    logic [IDX_W-1:0] slot;
    logic             inserted;
    logic             dropped;
  } srch_res_t;

  // counter update request
  typedef struct packed {
    logic [IDX_W-1:0]  slot;
    logic              fresh;
    logic              sender;
    logic [KIND_W-1:0] kind;
    logic [LEN_W-1:0]  len;
  } upd_req_t;

  // counter values after an update
  typedef struct packed {
    logic [PKT_W-1:0]  pkt_cnt;
    logic [BYTE_W-1:0] byte_total;
    logic [KD_W-1:0]   kd_cnt;
  } cnt_res_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_SEARCH,
    T_UPDATE,
    T_EMIT
  } top_state_t;

  typedef enum logic {
    SR_IDLE,
    SR_SCAN
  } srch_state_t;

  typedef enum logic {
    CN_IDLE,
    CN_UPD
  } cnt_state_t;

endpackage

### sv/phtc_search.sv
// Host address store with a linear search sequencer and slot allocation.
// Depends on phtc_pkg; one shared comparator checks one stored host per cycle.
module phtc_search
  import phtc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ADDR_W-1:0] key_in,
  output logic              done,
  output srch_res_t         res
);

  logic [ADDR_W-1:0] host_mem [TABLE_ENTRIES];

  srch_state_t       state, state_next;
  logic [CNT_W-1:0]  used, used_next;
  logic [CNT_W-1:0]  issue_idx, issue_idx_next;
  logic              rd_pend, rd_pend_next;
  logic [IDX_W-1:0]  rd_slot, rd_slot_next;
  logic [ADDR_W-1:0] key;
  logic [ADDR_W-1:0] rd_data;
  logic              done_next;
  srch_res_t         res_next;
  logic              mem_re, mem_we;
  logic [IDX_W-1:0]  mem_ra, mem_wa;
  logic              hit;

  // host store: one read and one write port
  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data <= host_mem[mem_ra];
    end
    if (mem_we) begin
      host_mem[mem_wa] <= key;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= SR_IDLE;
      used      <= '0;
      issue_idx <= '0;
      rd_pend   <= 1'b0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      used      <= used_next;
      issue_idx <= issue_idx_next;
      rd_pend   <= rd_pend_next;
      done      <= done_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (start && state == SR_IDLE) begin
      key <= key_in;
    end
    rd_slot <= rd_slot_next;
    res     <= res_next;
  end

  assign hit = rd_pend && (rd_data == key);

  // scan sequencer: issue a read each cycle, compare the previous one
  always_comb begin
    state_next     = state;
    used_next      = used;
    issue_idx_next = issue_idx;
    rd_pend_next   = rd_pend;
    rd_slot_next   = rd_slot;
    done_next      = 1'b0;
    res_next       = res;
    mem_re         = 1'b0;
    mem_ra         = issue_idx[IDX_W-1:0];
    mem_we         = 1'b0;
    mem_wa         = used[IDX_W-1:0];
    unique case (state)
      SR_IDLE: begin
        if (start) begin
          issue_idx_next = '0;
          rd_pend_next   = 1'b0;
          state_next     = SR_SCAN;
        end
      end
      SR_SCAN: begin
        if (hit) begin
          rd_pend_next      = 1'b0;
          done_next         = 1'b1;
          res_next.slot     = rd_slot;
          res_next.inserted = 1'b0;
          res_next.dropped  = 1'b0;
          state_next        = SR_IDLE;
        end else if (issue_idx < used) begin
          mem_re         = 1'b1;
          rd_pend_next   = 1'b1;
          rd_slot_next   = issue_idx[IDX_W-1:0];
          issue_idx_next = CNT_W'(issue_idx + 1'b1);
        end else if (rd_pend) begin
          // last compare missed, nothing left to read
          rd_pend_next = 1'b0;
        end else if (used == CNT_W'(TABLE_ENTRIES)) begin
          // new host, no free slot
          done_next         = 1'b1;
          res_next.slot     = '0;
          res_next.inserted = 1'b0;
          res_next.dropped  = 1'b1;
          state_next        = SR_IDLE;
        end else begin
          // new host takes the next free slot
          mem_we            = 1'b1;
          used_next         = CNT_W'(used + 1'b1);
          done_next         = 1'b1;
          res_next.slot     = used[IDX_W-1:0];
          res_next.inserted = 1'b1;
          res_next.dropped  = 1'b0;
          state_next        = SR_IDLE;
        end
      end
      default: begin
        state_next = SR_IDLE;
      end
    endcase
  end

endmodule

### sv/phtc_counters.sv
// Per-host counter store with a read-modify-write update of one slot.
// Depends on phtc_pkg; a fresh slot reads as all-zero counters.
module phtc_counters
  import phtc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  upd_req_t req_in,
  output logic     done,
  output cnt_res_t res
);

  entry_t  ent_mem [TABLE_ENTRIES];
  kd_row_t kd_mem  [TABLE_ENTRIES];

  cnt_state_t        state, state_next;
  upd_req_t          req;
  entry_t            ent_q;
  kd_row_t           kd_q;
  entry_t            base, ent_nxt;
  kd_row_t           row, row_nxt;
  logic [LANE_W-1:0] lane;
  logic              we;
  logic              done_next;
  cnt_res_t          res_next;

  // counter stores: row read at start, row write on update
  always_ff @(posedge clk) begin
    if (start && state == CN_IDLE) begin
      ent_q <= ent_mem[req_in.slot];
      kd_q  <= kd_mem[req_in.slot];
      req   <= req_in;
    end
    if (we) begin
      ent_mem[req.slot] <= ent_nxt;
      kd_mem[req.slot]  <= row_nxt;
    end
    res <= res_next;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CN_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // new counter values
  always_comb begin
    base    = req.fresh ? '0 : ent_q;
    row     = req.fresh ? '0 : kd_q;
    lane    = {req.kind, req.sender};
    ent_nxt = base;
    if (req.sender) begin
      ent_nxt.sent_pkts  = PKT_W'(base.sent_pkts + 1'b1);
      ent_nxt.sent_bytes = BYTE_W'(base.sent_bytes + BYTE_W'(req.len));
    end else begin
      ent_nxt.rcvd_pkts  = PKT_W'(base.rcvd_pkts + 1'b1);
      ent_nxt.rcvd_bytes = BYTE_W'(base.rcvd_bytes + BYTE_W'(req.len));
    end
    ent_nxt.all_bytes = BYTE_W'(base.all_bytes + BYTE_W'(req.len));
    row_nxt       = row;
    row_nxt[lane] = KD_W'(row[lane] + 1'b1);
  end

  // sequencer
  always_comb begin
    state_next = state;
    we         = 1'b0;
    done_next  = 1'b0;
    res_next   = res;
    unique case (state)
      CN_IDLE: begin
        if (start) begin
          state_next = CN_UPD;
        end
      end
      CN_UPD: begin
        we                  = 1'b1;
        done_next           = 1'b1;
        res_next.pkt_cnt    = PKT_W'(ent_nxt.sent_pkts + ent_nxt.rcvd_pkts);
        res_next.byte_total = ent_nxt.all_bytes;
        res_next.kd_cnt     = row_nxt[lane];
        state_next          = CN_IDLE;
      end
      default: begin
        state_next = CN_IDLE;
      end
    endcase
  end

endmodule

### sv/per_host_traffic_counter_table.sv
// Per-host traffic counter table: top level with stream ports and sequencer.
// Depends on phtc_pkg, phtc_search, phtc_counters and the assertion macros.
//
//   channel   dir  tdata                                         tuser
//   s_axis    in   host_address, packet_length                   is_sender, traffic_kind
//   m_axis    out  entry_index, entry_packet_count,              was_inserted, dropped_full
//                  entry_byte_total, kind_direction_count
//
// For each packet record the search reads one stored host per cycle from the
// host store; then, unless the record is dropped, one read-modify-write of
// the slot's counter rows follows, and then the output register is loaded.
// Reset clears the slot fill count; the stores themselves need no clearing.
// A new record is taken once the previous result sits in the output register.
`include "per_host_traffic_counter_table_defines.svh"
module per_host_traffic_counter_table
  import phtc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // host_address [31:0], packet_length [47:32]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // is_sender [0], traffic_kind [2:1]
  input  logic [S_TUSER_W-1:0] s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // entry_index [5:0], entry_packet_count [37:6], entry_byte_total [85:38],
  // kind_direction_count [117:86], zero [119:118]
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // was_inserted [0], dropped_full [1]
  output logic [M_TUSER_W-1:0] m_axis_tuser
);

  top_state_t          state, state_next;
  logic                in_xfer;
  logic                srch_done;
  srch_res_t           srch_res;
  logic                cnt_start;
  logic                cnt_done;
  upd_req_t            cnt_req;
  cnt_res_t            cnt_res;
  logic                sender;
  logic [KIND_W-1:0]   kind;
  logic [LEN_W-1:0]    len;
  logic [IDX_W-1:0]    pend_slot;
  logic                pend_ins;
  logic                pend_drop;
  logic                out_load;
  logic                out_valid_next;
  logic [OUT_IDX_W-1:0] out_index;
  logic                out_ins, out_drop;
  logic [PKT_W-1:0]    out_pkt;
  logic [BYTE_W-1:0]   out_bytes;
  logic [KD_W-1:0]     out_kd;

  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // table search
  phtc_search u_search (
    .clk    (clk),
    .rst    (rst),
    .start  (in_xfer),
    .key_in (s_axis_tdata[ADDR_W-1:0]),
    .done   (srch_done),
    .res    (srch_res)
  );

  // counter update request
  always_comb begin
    cnt_req.slot   = srch_res.slot;
    cnt_req.fresh  = srch_res.inserted;
    cnt_req.sender = sender;
    cnt_req.kind   = kind;
    cnt_req.len    = len;
  end

  phtc_counters u_counters (
    .clk    (clk),
    .rst    (rst),
    .start  (cnt_start),
    .req_in (cnt_req),
    .done   (cnt_done),
    .res    (cnt_res)
  );

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= T_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      state         <= state_next;
      m_axis_tvalid <= out_valid_next;
    end
  end

  // record and result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sender <= s_axis_tuser[0];
      kind   <= s_axis_tuser[S_TUSER_W-1:1];
      len    <= s_axis_tdata[ADDR_W +: LEN_W];
    end
    if (srch_done) begin
      pend_slot <= srch_res.slot;
      pend_ins  <= srch_res.inserted;
      pend_drop <= srch_res.dropped;
    end
    if (out_load) begin
      out_index <= OUT_IDX_W'(pend_slot);
      out_ins   <= pend_ins;
      out_drop  <= pend_drop;
      out_pkt   <= pend_drop ? '0 : cnt_res.pkt_cnt;
      out_bytes <= pend_drop ? '0 : cnt_res.byte_total;
      out_kd    <= pend_drop ? '0 : cnt_res.kd_cnt;
    end
  end

  // sequencer
  always_comb begin
    state_next     = state;
    s_axis_tready  = 1'b0;
    cnt_start      = 1'b0;
    out_load       = 1'b0;
    out_valid_next = m_axis_tready ? 1'b0 : m_axis_tvalid;
    unique case (state)
      T_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_next = T_SEARCH;
        end
      end
      T_SEARCH: begin
        if (srch_done) begin
          if (srch_res.dropped) begin
            state_next = T_EMIT;
          end else begin
            cnt_start  = 1'b1;
            state_next = T_UPDATE;
          end
        end
      end
      T_UPDATE: begin
        if (cnt_done) begin
          state_next = T_EMIT;
        end
      end
      T_EMIT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = T_IDLE;
        end
      end
      default: begin
        state_next = T_IDLE;
      end
    endcase
  end

  // output packing
  assign m_axis_tdata = M_TDATA_W'({out_kd, out_bytes, out_pkt, out_index});
  assign m_axis_tuser = {out_drop, out_ins};

  // checks
  `PHTC_ASSERT_IMP(a_srch_done_state, srch_done, state == T_SEARCH)
  `PHTC_ASSERT_IMP(a_cnt_done_state, cnt_done, state == T_UPDATE)
  `PHTC_ASSERT_IMP(a_srch_outcome, srch_done, !(srch_res.inserted && srch_res.dropped))
  `PHTC_ASSERT_NXT(a_emit_holds, state == T_EMIT && m_axis_tvalid && !m_axis_tready, state == T_EMIT)

endmodule

### test/per_host_traffic_counter_table_tb.sv
// Self-checking testbench for the per-host traffic counter table stream block.
// Depends on phtc_pkg and per_host_traffic_counter_table; predicts every result
// from its own copy of the host table and counters.
module per_host_traffic_counter_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import phtc_pkg::*;

  // traffic kind codes carried in tuser
  typedef enum bit [KIND_W-1:0] {
    KIND_TCP   = 2'd0,
    KIND_UDP   = 2'd1,
    KIND_ICMP  = 2'd2,
    KIND_OTHER = 2'd3
  } traffic_kind_t;

  // direction flag values
  localparam bit DIR_RECEIVED = 1'b0;
  localparam bit DIR_SENT     = 1'b1;

  // result field positions on the master side
  localparam int PKT_LSB      = OUT_IDX_W;
  localparam int BYTE_LSB     = PKT_LSB + PKT_W;
  localparam int KD_LSB       = BYTE_LSB + BYTE_W;
  localparam int INSERTED_BIT = 0;
  localparam int DROPPED_BIT  = 1;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int HOLD_CYCLES    = 400;

  // one update result
  typedef struct packed {
    logic [OUT_IDX_W-1:0] slot;
    logic                 inserted;
    logic                 dropped;
    logic [PKT_W-1:0]     pkts;
    logic [BYTE_W-1:0]    bytes;
    logic [KD_W-1:0]      kind_pkts;
  } host_update_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [S_TUSER_W-1:0] s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [M_TUSER_W-1:0] m_axis_tuser;

  // own copy of the host table
  bit [ADDR_W-1:0] host_addr   [TABLE_ENTRIES];
  bit [PKT_W-1:0]  sent_pkts   [TABLE_ENTRIES];
  bit [PKT_W-1:0]  rcvd_pkts   [TABLE_ENTRIES];
  bit [BYTE_W-1:0] sent_bytes  [TABLE_ENTRIES];
  bit [BYTE_W-1:0] rcvd_bytes  [TABLE_ENTRIES];
  bit [BYTE_W-1:0] total_bytes [TABLE_ENTRIES];
  bit [KD_W-1:0]   kind_pkts   [TABLE_ENTRIES][KD_LANES];
  int              hosts_used = 0;

  host_update_t pending_updates[$];
  int           mismatch_count = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           hold_request = 0;
  int           hold_left = 0;
  int           quiet_cycles = 0;

  per_host_traffic_counter_table uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk = ~clk;

  // look up or insert the host, then bump its counters
  function automatic host_update_t count_packet(bit [ADDR_W-1:0] addr, bit sender,
                                                traffic_kind_t kind, bit [LEN_W-1:0] len);
    host_update_t upd;
    int           slot;
    int           lane;
    int           i;
    upd  = '0;
    slot = -1;
    for (i = 0; i < hosts_used; i++) begin
      if (slot < 0 && host_addr[i] == addr) begin
        slot = i;
      end
    end
    if (slot < 0) begin
      // new host with the table full: dropped, nothing changes
      if (hosts_used >= TABLE_ENTRIES) begin
        upd.dropped = 1'b1;
        return upd;
      end
      slot = hosts_used;
      hosts_used++;
      upd.inserted      = 1'b1;
      host_addr[slot]   = addr;
      sent_pkts[slot]   = '0;
      rcvd_pkts[slot]   = '0;
      sent_bytes[slot]  = '0;
      rcvd_bytes[slot]  = '0;
      total_bytes[slot] = '0;
      for (i = 0; i < KD_LANES; i++) begin
        kind_pkts[slot][i] = '0;
      end
    end
    // counters wrap at their own widths
    if (sender) begin
      sent_pkts[slot]  += 1;
      sent_bytes[slot] += len;
    end else begin
      rcvd_pkts[slot]  += 1;
      rcvd_bytes[slot] += len;
    end
    total_bytes[slot] += len;
    lane = int'(kind) * 2 + int'(sender);
    kind_pkts[slot][lane] += 1;
    upd.slot      = OUT_IDX_W'(slot);
    upd.pkts      = sent_pkts[slot] + rcvd_pkts[slot];
    upd.bytes     = total_bytes[slot];
    upd.kind_pkts = kind_pkts[slot][lane];
    return upd;
  endfunction

  // offer one packet record and note its expected result once transferred
  task automatic send_record(bit [ADDR_W-1:0] addr, bit sender, traffic_kind_t kind,
                             bit [LEN_W-1:0] len);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {len, addr};
    s_axis_tuser  <= {kind, sender};
    do @(posedge clk); while (!s_axis_tready);
    pending_updates.push_back(count_packet(addr, sender, kind, len));
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
  endtask

  task automatic compare_field(string field, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // receiver: check each transfer, then choose the next ready
  always @(posedge clk) begin
    host_update_t want;
    host_update_t got;
    if (m_axis_tvalid && m_axis_tready) begin
      got.slot      = m_axis_tdata[OUT_IDX_W-1:0];
      got.pkts      = m_axis_tdata[PKT_LSB +: PKT_W];
      got.bytes     = m_axis_tdata[BYTE_LSB +: BYTE_W];
      got.kind_pkts = m_axis_tdata[KD_LSB +: KD_W];
      got.inserted  = m_axis_tuser[INSERTED_BIT];
      got.dropped   = m_axis_tuser[DROPPED_BIT];
      if (pending_updates.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual %0h", $time, got);
        mismatch_count++;
      end else begin
        want = pending_updates.pop_front();
        compare_field("entry_index", want.slot, got.slot);
        compare_field("was_inserted", want.inserted, got.inserted);
        compare_field("dropped_full", want.dropped, got.dropped);
        compare_field("entry_packet_count", want.pkts, got.pkts);
        compare_field("entry_byte_total", want.bytes, got.bytes);
        compare_field("kind_direction_count", want.kind_pkts, got.kind_pkts);
      end
    end
    // long hold-off when asked, else random stalls
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request <= 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[per_host_traffic_counter_table] ERROR");
      $finish;
    end
  end

  // first hosts, with the extremes of address and length
  task automatic test_new_hosts();
    send_record(32'h0000_0000, DIR_RECEIVED, KIND_TCP, 16'h0000);
    send_record(32'hFFFF_FFFF, DIR_SENT, KIND_OTHER, 16'hFFFF);
    send_record(32'hA5A5_5A5A, DIR_SENT, KIND_UDP, 16'h5AA5);
    send_record(32'h5A5A_A5A5, DIR_RECEIVED, KIND_ICMP, 16'hA55A);
  endtask

  // every kind and direction counter of one host
  task automatic test_kind_direction();
    int k;
    for (k = 0; k < 2 * KD_LANES / 2; k++) begin
      send_record(32'h0000_0000, k[0], traffic_kind_t'(k >> 1), k[0] ? 16'hFFFF : 16'h0001);
    end
  endtask

  // addresses one bit away from stored hosts must be new hosts; the stored hosts then count again
  task automatic test_near_miss();
    send_record(32'h0000_0001, DIR_SENT, KIND_TCP, 16'hFFFF);
    send_record(32'h8000_0000, DIR_RECEIVED, KIND_UDP, 16'hFFFF);
    send_record(32'hFFFF_FFFE, DIR_SENT, KIND_ICMP, 16'h0000);
    send_record(32'hFFFF_FFFF, DIR_RECEIVED, KIND_OTHER, 16'hFFFF);
    send_record(32'h0000_0000, DIR_SENT, KIND_OTHER, 16'hFFFF);
  endtask

  // mostly known hosts, some near misses and fresh addresses
  task automatic send_random_traffic(int count);
    int              pick;
    int              len_pick;
    bit [ADDR_W-1:0] addr;
    bit [LEN_W-1:0]  len;
    repeat (count) begin
      pick = $urandom_range(99);
      if (hosts_used > 0 && pick < 80) begin
        addr = host_addr[$urandom_range(hosts_used - 1)];
      end else if (hosts_used > 0 && pick < 88) begin
        addr = host_addr[$urandom_range(hosts_used - 1)] ^ (32'h1 << $urandom_range(31));
      end else begin
        addr = $urandom();
      end
      len_pick = $urandom_range(9);
      if (len_pick == 0) begin
        len = '0;
      end else if (len_pick == 1) begin
        len = '1;
      end else begin
        len = LEN_W'($urandom());
      end
      send_record(addr, 1'($urandom_range(1)), traffic_kind_t'($urandom_range(3)), len);
    end
  endtask

  // random traffic under each idling pattern
  task automatic test_random_phases();
    send_idle_pct = 0;  recv_stall_pct = 0;  send_random_traffic(480);
    send_idle_pct = 50; recv_stall_pct = 0;  send_random_traffic(480);
    send_idle_pct = 0;  recv_stall_pct = 50; send_random_traffic(480);
    send_idle_pct = 28; recv_stall_pct = 28; send_random_traffic(480);
  endtask

  // fill every slot, then new hosts are dropped while known ones still count
  task automatic test_table_full();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (hosts_used < TABLE_ENTRIES) begin
      send_record($urandom(), DIR_SENT, KIND_TCP, 16'h0040);
    end
    send_record(32'hDEAD_0001, DIR_SENT, KIND_UDP, 16'hFFFF);
    send_record(32'hDEAD_0002, DIR_RECEIVED, KIND_OTHER, 16'h0001);
    send_record(host_addr[TABLE_ENTRIES - 1], DIR_RECEIVED, KIND_ICMP, 16'hFFFF);
    send_record(host_addr[0], DIR_SENT, KIND_TCP, 16'h0000);
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request <= HOLD_CYCLES;
    send_random_traffic(12);
  endtask

  // sender pauses until the block has emptied, then resumes
  task automatic test_drain_pause();
    send_idle_pct  = 28;
    recv_stall_pct = 28;
    send_random_traffic(10);
    wait_results_drained();
    send_random_traffic(10);
  endtask

  // test sequence
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_new_hosts();
    test_kind_direction();
    test_near_miss();
    test_random_phases();
    test_table_full();
    test_backpressure();
    test_drain_pause();
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[per_host_traffic_counter_table] OK");
    end else begin
      $display("[per_host_traffic_counter_table] ERROR");
    end
    $finish;
  end

endmodule
